// ----- src/sockrp_pkg.sv -----
package sockrp_pkg;

    localparam int POS_W = 9;
    localparam int LEN_W = POS_W + 1;

    localparam logic [POS_W-1:0] POS_MAX           = 9'd511;
    localparam logic [POS_W-1:0] POS_VERSION       = 9'd0;
    localparam logic [POS_W-1:0] POS_COMMAND       = 9'd1;
    localparam logic [POS_W-1:0] POS_RESERVED      = 9'd2;
    localparam logic [POS_W-1:0] POS_ADDR_TYPE     = 9'd3;
    localparam logic [POS_W-1:0] ADDR_START        = 9'd4;
    localparam logic [POS_W-1:0] DOMAIN_DATA_START = 9'd5;
    localparam logic [POS_W-1:0] IPV4_PORT_POS     = 9'd8;
    localparam logic [POS_W-1:0] IPV6_PORT_POS     = 9'd20;

    localparam logic [LEN_W-1:0] MIN_LEN          = 10'd6;
    localparam logic [LEN_W-1:0] IPV4_LEN         = 10'd10;
    localparam logic [LEN_W-1:0] IPV6_LEN         = 10'd22;
    localparam logic [LEN_W-1:0] DOMAIN_FIXED_LEN = 10'd7;

    localparam logic [7:0] ATYP_IPV4      = 8'd1;
    localparam logic [7:0] ATYP_DOMAIN    = 8'd3;
    localparam logic [7:0] ATYP_IPV6      = 8'd4;
    localparam logic [7:0] CMD_CONNECT    = 8'd1;
    localparam logic [7:0] CMD_BIND       = 8'd2;
    localparam logic [7:0] CMD_UDP_ASSOC  = 8'd3;
    localparam logic [7:0] RESERVED_VALUE = 8'h00;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_SHORT    = 3'd1;
    localparam logic [2:0] ERR_VERSION  = 3'd2;
    localparam logic [2:0] ERR_RESERVED = 3'd3;
    localparam logic [2:0] ERR_COMMAND  = 3'd4;
    localparam logic [2:0] ERR_ATYPE    = 3'd5;
    localparam logic [2:0] ERR_LENGTH   = 3'd6;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_VERSION  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CMD_MASK = 8'd1;

    localparam logic [7:0] VERSION_RESET  = 8'd5;
    localparam logic [2:0] CMD_MASK_RESET = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } sockrp_in_t;

    typedef struct packed {
        logic        is_address_byte;
        logic [7:0]  address_byte;
        logic [7:0]  address_index;
        logic        message_done;
        logic        accepted;
        logic [2:0]  error_code;
        logic [7:0]  command_code;
        logic [7:0]  address_kind;
        logic [15:0] port_number;
    } sockrp_out_t;

    typedef struct packed {
        logic [7:0] supported_version;
        logic [2:0] command_enable_mask;
    } sockrp_cfg_t;

    function automatic logic [2:0] note_error(input logic [2:0] cur, input logic [2:0] code);
        logic [2:0] res;
        res = cur;
        if (cur == ERR_NONE || code < cur) begin
            res = code;
        end
        return res;
    endfunction

endpackage

// ----- src/sockrp_core.sv -----
module sockrp_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  sockrp_pkg::sockrp_in_t  item,
    input  sockrp_pkg::sockrp_cfg_t cfg,
    output sockrp_pkg::sockrp_out_t result
);
    import sockrp_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [2:0]       err_reg,   err_next;
    logic [7:0]       cmd_reg,   cmd_next;
    logic [7:0]       kind_reg,  kind_next;
    logic [7:0]       dlen_reg,  dlen_next;
    logic [7:0]       phigh_reg, phigh_next;
    logic [7:0]       plow_reg,  plow_next;

    logic [7:0]       b;
    logic             is_addr;
    logic [POS_W-1:0] addr_idx;
    logic [POS_W-1:0] port_pos;
    logic [POS_W-1:0] domain_end;
    logic             has_port;
    logic             cmd_ok;
    logic [LEN_W-1:0] total;
    logic [LEN_W-1:0] expect_len;
    logic [2:0]       err_out;

    assign b          = item.data_byte;
    assign domain_end = {1'b0, dlen_reg} + DOMAIN_DATA_START;
    assign cmd_ok     = (b == CMD_CONNECT   && cfg.command_enable_mask[0])
                     || (b == CMD_BIND      && cfg.command_enable_mask[1])
                     || (b == CMD_UDP_ASSOC && cfg.command_enable_mask[2]);

    always_comb begin
        err_next   = err_reg;
        cmd_next   = cmd_reg;
        kind_next  = kind_reg;
        dlen_next  = dlen_reg;
        phigh_next = phigh_reg;
        plow_next  = plow_reg;
        is_addr    = 1'b0;
        addr_idx   = '0;
        port_pos   = '0;
        has_port   = 1'b0;

        unique case (pos_reg)
            POS_VERSION: begin
                if (b != cfg.supported_version) begin
                    err_next = note_error(err_reg, ERR_VERSION);
                end
            end
            POS_COMMAND: begin
                cmd_next = b;
                if (!cmd_ok) begin
                    err_next = note_error(err_reg, ERR_COMMAND);
                end
            end
            POS_RESERVED: begin
                if (b != RESERVED_VALUE) begin
                    err_next = note_error(err_reg, ERR_RESERVED);
                end
            end
            POS_ADDR_TYPE: begin
                kind_next = b;
                if (b != ATYP_IPV4 && b != ATYP_DOMAIN && b != ATYP_IPV6) begin
                    err_next = note_error(err_reg, ERR_ATYPE);
                end
            end
            default: begin
                unique case (kind_reg)
                    ATYP_IPV4: begin
                        if (pos_reg < IPV4_PORT_POS) begin
                            is_addr  = 1'b1;
                            addr_idx = pos_reg - ADDR_START;
                        end
                        port_pos = IPV4_PORT_POS;
                        has_port = 1'b1;
                    end
                    ATYP_IPV6: begin
                        if (pos_reg < IPV6_PORT_POS) begin
                            is_addr  = 1'b1;
                            addr_idx = pos_reg - ADDR_START;
                        end
                        port_pos = IPV6_PORT_POS;
                        has_port = 1'b1;
                    end
                    ATYP_DOMAIN: begin
                        if (pos_reg == ADDR_START) begin
                            dlen_next = b;
                        end else if (pos_reg < domain_end) begin
                            is_addr  = 1'b1;
                            addr_idx = pos_reg - DOMAIN_DATA_START;
                        end
                        port_pos = domain_end;
                        has_port = 1'b1;
                    end
                    default: begin
                        has_port = 1'b0;
                    end
                endcase
                if (has_port) begin
                    if (pos_reg == port_pos) begin
                        phigh_next = b;
                    end else if (pos_reg == port_pos + 9'd1) begin
                        plow_next = b;
                    end
                end
            end
        endcase
    end

    assign total = {1'b0, pos_reg} + LEN_W'(1);

    always_comb begin
        if (kind_next == ATYP_IPV4) begin
            expect_len = IPV4_LEN;
        end else if (kind_next == ATYP_IPV6) begin
            expect_len = IPV6_LEN;
        end else begin
            expect_len = {2'b00, dlen_next} + DOMAIN_FIXED_LEN;
        end

        err_out = ERR_NONE;
        if (item.last_byte) begin
            if (total < MIN_LEN) begin
                err_out = ERR_SHORT;
            end else if (err_next != ERR_NONE) begin
                err_out = err_next;
            end else if (total != expect_len) begin
                err_out = ERR_LENGTH;
            end
        end
    end

    always_comb begin
        result.is_address_byte = is_addr;
        result.address_byte    = is_addr ? b : 8'd0;
        result.address_index   = addr_idx[7:0];
        result.message_done    = item.last_byte;
        result.accepted        = item.last_byte && (err_out == ERR_NONE);
        result.error_code      = err_out;
        result.command_code    = cmd_next;
        result.address_kind    = kind_next;
        result.port_number     = {phigh_next, plow_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            err_reg   <= ERR_NONE;
            cmd_reg   <= '0;
            kind_reg  <= '0;
            dlen_reg  <= '0;
            phigh_reg <= '0;
            plow_reg  <= '0;
        end else if (step) begin
            if (item.last_byte) begin
                pos_reg   <= '0;
                err_reg   <= ERR_NONE;
                cmd_reg   <= '0;
                kind_reg  <= '0;
                dlen_reg  <= '0;
                phigh_reg <= '0;
                plow_reg  <= '0;
            end else begin
                if (pos_reg != POS_MAX) begin
                    pos_reg <= pos_reg + 9'd1;
                end
                err_reg   <= err_next;
                cmd_reg   <= cmd_next;
                kind_reg  <= kind_next;
                dlen_reg  <= dlen_next;
                phigh_reg <= phigh_next;
                plow_reg  <= plow_next;
            end
        end
    end

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.last_byte |=> pos_reg == '0 && err_reg == ERR_NONE && kind_reg == '0)
        else $error("state not cleared after final word");

    a_pos_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !item.last_byte && pos_reg != POS_MAX |=> pos_reg == $past(pos_reg) + 9'd1)
        else $error("position did not advance");

    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(pos_reg) && $stable(err_reg))
        else $error("state moved without a word");

    a_accept_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        result.accepted |-> result.message_done && result.error_code == ERR_NONE)
        else $error("accept flagged with error");

endmodule

// ----- src/socks_request_parser.sv -----
// An accepted word passes the input stage, then the result stage, to reach m_.
// Throughput: one word per cycle while m_ready is high; s_ready is then high too.
// Input and result stages each hold one word; stalls propagate stage by stage.
// Reset (aresetn low, synchronous) empties both stages, clears the parse state
// and loads supported_version = 5 and command_enable_mask = 7.
module socks_request_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sockrp_pkg::sockrp_in_t              s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sockrp_pkg::sockrp_out_t             m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sockrp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sockrp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sockrp_pkg::*;

    logic        in_valid_reg;
    sockrp_in_t  in_data_reg;
    logic        out_valid_reg;
    sockrp_out_t out_data_reg;
    sockrp_cfg_t cfg_reg;
    sockrp_out_t step_result;
    logic        adv;
    logic        step;

    assign adv       = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && adv;
    assign s_ready   = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    sockrp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.supported_version   <= VERSION_RESET;
            cfg_reg.command_enable_mask <= CMD_MASK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_IDX_VERSION:  cfg_reg.supported_version   <= cfg_data[7:0];
                CFG_IDX_CMD_MASK: cfg_reg.command_enable_mask <= cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (step) begin
            out_data_reg <= step_result;
        end
    end

    a_step_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid)
        else $error("processed word missing at output");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !adv |=> in_valid_reg && $stable(in_data_reg))
        else $error("input stage lost a stalled word");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("stages not empty after reset");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import sockrp_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int SEGMENTS = 6;
    localparam int DIRECTED_ROWS = 24;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       typed;
        logic [2:0] code;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    sockrp_in_t  s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    sockrp_out_t m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic [7:0] ver_cfg = VERSION_RESET;
    logic [2:0] mask_cfg = CMD_MASK_RESET;
    logic [8:0] pos_cnt = '0;
    logic [2:0] pend_err = ERR_NONE;
    logic [7:0] cmd_hold = '0;
    logic [7:0] atyp_hold = '0;
    logic [7:0] dom_len = '0;
    logic [7:0] port_hi = '0;
    logic [7:0] port_lo = '0;

    sockrp_out_t parse_results_q[$];
    sockrp_out_t exp_word;
    int items_sent = 0;
    int fail_count = 0;
    int quiet_cycles = 0;
    int src_idle_pct = 24;
    int dst_idle_pct = 66;

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'hFF, 1'b1, 1'b1, ERR_SHORT},
        '{8'h00, 1'b0, 1'b0, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, ERR_NONE},
        '{8'h02, 1'b0, 1'b0, ERR_NONE},
        '{8'h12, 1'b0, 1'b0, ERR_NONE},
        '{8'h34, 1'b1, 1'b1, ERR_VERSION},
        '{8'h05, 1'b0, 1'b0, ERR_NONE},
        '{8'h01, 1'b0, 1'b0, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, ERR_NONE},
        '{8'h01, 1'b0, 1'b0, ERR_NONE},
        '{8'hC0, 1'b0, 1'b0, ERR_NONE},
        '{8'hA8, 1'b0, 1'b0, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, ERR_NONE},
        '{8'h01, 1'b0, 1'b0, ERR_NONE},
        '{8'h1F, 1'b0, 1'b0, ERR_NONE},
        '{8'h90, 1'b1, 1'b1, ERR_NONE},
        '{8'h05, 1'b0, 1'b0, ERR_NONE},
        '{8'h03, 1'b0, 1'b0, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, ERR_NONE},
        '{8'h03, 1'b0, 1'b0, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, ERR_NONE},
        '{8'hFF, 1'b1, 1'b1, ERR_NONE}
    };

    socks_request_parser u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic void flag_error(input logic [2:0] code);
        if (pend_err == ERR_NONE || code < pend_err) begin
            pend_err = code;
        end
    endfunction

    function automatic sockrp_out_t parse_byte(input logic [7:0] b, input logic last);
        sockrp_out_t w;
        logic [2:0] code;
        logic [LEN_W-1:0] total;
        logic [LEN_W-1:0] want_len;
        logic [POS_W-1:0] port_at;
        logic has_port;
        w = '0;
        code = ERR_NONE;
        port_at = '0;
        has_port = 1'b0;
        case (pos_cnt)
            POS_VERSION: begin
                if (b != ver_cfg) flag_error(ERR_VERSION);
            end
            POS_COMMAND: begin
                cmd_hold = b;
                if (!(b >= CMD_CONNECT && b <= CMD_UDP_ASSOC && mask_cfg[b[1:0] - 2'd1]))
                    flag_error(ERR_COMMAND);
            end
            POS_RESERVED: begin
                if (b != RESERVED_VALUE) flag_error(ERR_RESERVED);
            end
            POS_ADDR_TYPE: begin
                atyp_hold = b;
                if (b != ATYP_IPV4 && b != ATYP_DOMAIN && b != ATYP_IPV6)
                    flag_error(ERR_ATYPE);
            end
            default: begin
                if (atyp_hold == ATYP_IPV4 || atyp_hold == ATYP_IPV6) begin
                    port_at = (atyp_hold == ATYP_IPV4) ? IPV4_PORT_POS : IPV6_PORT_POS;
                    has_port = 1'b1;
                    if (pos_cnt < port_at) begin
                        w.is_address_byte = 1'b1;
                        w.address_index = 8'(pos_cnt - ADDR_START);
                    end
                end else if (atyp_hold == ATYP_DOMAIN) begin
                    if (pos_cnt == ADDR_START) begin
                        dom_len = b;
                    end else if (pos_cnt < DOMAIN_DATA_START + dom_len) begin
                        w.is_address_byte = 1'b1;
                        w.address_index = 8'(pos_cnt - DOMAIN_DATA_START);
                    end
                    port_at = DOMAIN_DATA_START + dom_len;
                    has_port = 1'b1;
                end
                if (has_port) begin
                    if (pos_cnt == port_at) port_hi = b;
                    else if (pos_cnt == port_at + 9'd1) port_lo = b;
                end
            end
        endcase

        if (last) begin
            total = {1'b0, pos_cnt} + 10'd1;
            if (total < MIN_LEN) begin
                code = ERR_SHORT;
            end else if (pend_err != ERR_NONE) begin
                code = pend_err;
            end else begin
                if (atyp_hold == ATYP_IPV4) want_len = IPV4_LEN;
                else if (atyp_hold == ATYP_IPV6) want_len = IPV6_LEN;
                else want_len = DOMAIN_FIXED_LEN + dom_len;
                if (total != want_len) code = ERR_LENGTH;
            end
        end

        w.address_byte = w.is_address_byte ? b : 8'd0;
        w.message_done = last;
        w.accepted = last && code == ERR_NONE;
        w.error_code = code;
        w.command_code = cmd_hold;
        w.address_kind = atyp_hold;
        w.port_number = {port_hi, port_lo};

        if (last) begin
            pos_cnt = '0;
            pend_err = ERR_NONE;
            cmd_hold = '0;
            atyp_hold = '0;
            dom_len = '0;
            port_hi = '0;
            port_lo = '0;
        end else if (pos_cnt != POS_MAX) begin
            pos_cnt = pos_cnt + 9'd1;
        end
        return w;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input logic [2:0] code);
        sockrp_in_t word;
        sockrp_out_t want;
        word.data_byte = b;
        word.last_byte = last;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= word;
        want = parse_byte(b, last);
        if (typed) begin
            want.error_code = code;
            want.accepted = (code == ERR_NONE);
        end
        parse_results_q = {parse_results_q, want};
        items_sent++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_request(input bit long_msg);
        logic [7:0] msg[$];
        logic [7:0] atyp;
        int dl;
        int r;
        int cut;
        int target_len;
        msg = {msg, (($urandom_range(0, 99) < 85) ? ver_cfg : 8'($urandom_range(0, 255)))};
        msg = {msg, (($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 3))
                                                  : 8'($urandom_range(0, 255)))};
        msg = {msg, (($urandom_range(0, 99) < 90) ? RESERVED_VALUE
                                                  : 8'($urandom_range(0, 255)))};
        r = $urandom_range(0, 99);
        if (r < 30) atyp = ATYP_IPV4;
        else if (r < 55) atyp = ATYP_DOMAIN;
        else if (r < 85) atyp = ATYP_IPV6;
        else atyp = 8'($urandom_range(0, 255));
        msg = {msg, atyp};
        if (atyp == ATYP_IPV4) begin
            repeat (4) msg = {msg, 8'($urandom_range(0, 255))};
        end else if (atyp == ATYP_IPV6) begin
            repeat (16) msg = {msg, 8'($urandom_range(0, 255))};
        end else if (atyp == ATYP_DOMAIN) begin
            dl = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 15) : $urandom_range(16, 255);
            msg = {msg, 8'(dl)};
            repeat (dl) msg = {msg, 8'($urandom_range(0, 255))};
        end else begin
            repeat ($urandom_range(0, 8)) msg = {msg, 8'($urandom_range(0, 255))};
        end
        repeat (2) msg = {msg, 8'($urandom_range(0, 255))};

        r = $urandom_range(0, 99);
        if (r < 8) begin
            cut = $urandom_range(1, msg.size() - 1);
            while (msg.size() > cut) void'(msg.pop_back());
        end else if (r < 14) begin
            repeat ($urandom_range(1, 3)) msg = {msg, 8'($urandom_range(0, 255))};
        end
        if (long_msg) begin
            target_len = $urandom_range(512, 530);
            while (msg.size() < target_len) msg = {msg, 8'($urandom_range(0, 255))};
        end

        for (int i = 0; i < msg.size(); i++) begin
            send_byte(msg[i], i == msg.size() - 1, 1'b0, ERR_NONE);
        end
    endtask

    task automatic configure(input logic [7:0] version, input logic [2:0] mask);
        logic [CFG_INDEX_W-1:0] regs [2];
        logic [CFG_DATA_W-1:0] vals [2];
        regs[0] = CFG_IDX_VERSION;
        regs[1] = CFG_IDX_CMD_MASK;
        vals[0] = version;
        vals[1] = {5'($urandom_range(0, 31)), mask};
        for (int i = 0; i < 2; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        ver_cfg = version;
        mask_cfg = mask;
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (parse_results_q.size() == 0) begin
                $error("result word with no expectation waiting");
                fail_count++;
            end else begin
                exp_word = parse_results_q.pop_front();
                check_field("is_address_byte", 16'(exp_word.is_address_byte),
                            16'(m_data.is_address_byte));
                check_field("address_byte", 16'(exp_word.address_byte),
                            16'(m_data.address_byte));
                check_field("address_index", 16'(exp_word.address_index),
                            16'(m_data.address_index));
                check_field("message_done", 16'(exp_word.message_done),
                            16'(m_data.message_done));
                check_field("accepted", 16'(exp_word.accepted), 16'(m_data.accepted));
                check_field("error_code", 16'(exp_word.error_code), 16'(m_data.error_code));
                check_field("command_code", 16'(exp_word.command_code),
                            16'(m_data.command_code));
                check_field("address_kind", 16'(exp_word.address_kind),
                            16'(m_data.address_kind));
                check_field("port_number", exp_word.port_number, m_data.port_number);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] seg_version [SEGMENTS];
        logic [2:0] seg_mask [SEGMENTS];
        bit long_pending;
        seg_version = '{8'h00, 8'hFF, VERSION_RESET, 8'($urandom_range(0, 255)),
                        VERSION_RESET, VERSION_RESET};
        seg_mask = '{CMD_MASK_RESET, 3'd0, 3'd5, 3'd2, 3'd3, CMD_MASK_RESET};
        long_pending = 1'b1;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_byte(directed_rows[i].value, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].code);
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            // hold off until the pipeline is empty before touching the registers
            s_valid <= 1'b0;
            while (parse_results_q.size() != 0) @(negedge aclk);
            repeat (4) @(negedge aclk);
            case (seg / 2)
                0: begin
                    src_idle_pct = 24;
                    dst_idle_pct = 66;
                end
                1: begin
                    src_idle_pct = 66;
                    dst_idle_pct = 24;
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            configure(seg_version[seg], seg_mask[seg]);
            while (items_sent < DIRECTED_ROWS + (seg + 1) * RANDOM_ITEMS / SEGMENTS) begin
                send_request(seg == SEGMENTS - 1 && long_pending);
                if (seg == SEGMENTS - 1) long_pending = 1'b0;
            end
        end

        s_valid <= 1'b0;
        while (parse_results_q.size() != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
